>>> design/hkv_pkg.sv
// Package: payload types, operation and status codes, and control structs for the key-value table.
`timescale 1ns / 1ps

package hkv_pkg;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_hkv_in;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
    } t_hkv_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the request and read its bucket row
        logic commit;       // write the bucket back and load the result
        logic sweep_start;  // restart the clearing sweep at row zero
        logic sweep;        // clear the valid bits of one row and advance
        logic emit_clear;   // load the result of a clear operation
    } t_hkv_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_op;     // the captured request is a clear
        logic sweep_last;   // the sweep is at the last row
        logic out_free;     // the result register can take a new result
    } t_hkv_sts;

endpackage

>>> design/hashed_key_value_table.sv
// Top level of the hashed key-value table: controller and datapath.
`timescale 1ns / 1ps

// A key-value table of 32-bit keys and values in BUCKETS buckets of WAYS ways.
// A key's bucket is key AND (BUCKETS-1). Each request is a lookup, an insert
// or update, a remove, or a clear of the whole table, and gives one result.
// Lookup, insert and remove each read the bucket row from the synchronous row
// memory into registers, then write the row back and load the result register;
// the write-back waits while the result register is still occupied. A clear
// runs a sweep over all rows, one row a cycle, and then loads its result once
// the result register is free. After reset the same sweep empties the table
// before the first request is taken. The result register lets the next request
// enter while a result waits to be taken.
module hashed_key_value_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hkv_pkg::t_hkv_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hkv_pkg::t_hkv_out o_out
);
    import hkv_pkg::*;

    t_hkv_cmd cmd;
    t_hkv_sts sts;

    // Sequencing.
    hkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage, match logic and result register.
    hkv_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> design/hkv_ctrl.sv
// Controller state machine: sequences request capture, write-back and clearing sweeps.
`timescale 1ns / 1ps

module hkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hkv_pkg::t_hkv_sts i_sts,
    output hkv_pkg::t_hkv_cmd o_cmd
);
    import hkv_pkg::*;

    localparam logic [1:0] S_SWEEP  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;
    localparam logic [1:0] S_CLRRES = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_emit;
    logic       n_emit;

    // Requests are taken only while idle.
    assign o_in_stall = (r_state != S_IDLE);

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.clear_op) begin
                    o_cmd.sweep_start = 1'b1;
                    n_emit            = 1'b1;
                    n_state           = S_SWEEP;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_emit ? S_CLRRES : S_IDLE;
                end
            end
            S_CLRRES: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_clear = 1'b1;
                    n_emit           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; reset starts with a sweep that empties the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

endmodule

>>> design/hkv_datapath.sv
// Datapath: bucket row memories, way match and free-way search, and the result register.
`timescale 1ns / 1ps

module hkv_datapath #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hkv_pkg::t_hkv_in  i_in,
    input  hkv_pkg::t_hkv_cmd i_cmd,
    output hkv_pkg::t_hkv_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hkv_pkg::t_hkv_out o_out
);
    import hkv_pkg::*;

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [AW-1:0] BUCKET_MASK = AW'(BUCKETS - 1);
    localparam logic [AW-1:0] LAST_ROW    = AW'(BUCKETS - 1);

    // Row memories, one row per bucket holding all of its ways.
    logic [WAYS-1:0]    mem_vld [BUCKETS];
    logic [WAYS*32-1:0] mem_key [BUCKETS];
    logic [WAYS*32-1:0] mem_val [BUCKETS];

    // Captured request and the row read for it.
    logic [1:0]         r_mode;
    logic [31:0]        r_key;
    logic [31:0]        r_value_in;
    logic [AW-1:0]      r_bucket;
    logic [WAYS-1:0]    r_rd_vld;
    logic [WAYS*32-1:0] r_rd_key;
    logic [WAYS*32-1:0] r_rd_val;

    logic [AW-1:0]      r_sweep;
    logic               r_out_valid;
    t_hkv_out           r_out;

    logic [AW-1:0]      in_bucket;
    logic [WAYS-1:0]    hit;
    logic [WAYS-1:0]    free;
    logic [WAYS-1:0]    free_oh;
    logic               any_hit;
    logic               any_free;
    logic [31:0]        hit_val;
    logic [WAYS-1:0]    n_vld;
    logic [WAYS*32-1:0] n_key;
    logic [WAYS*32-1:0] n_val;
    logic               we_row;
    t_hkv_out           res;

    assign in_bucket = i_in.key[AW-1:0] & BUCKET_MASK;

    // Way compare and value select; at most one way holds a given key.
    always_comb begin
        hit_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit[w] = r_rd_vld[w] && (r_rd_key[w*32 +: 32] == r_key);
            if (hit[w]) begin
                hit_val = hit_val | r_rd_val[w*32 +: 32];
            end
        end
    end

    // Lowest free way as a one-hot vector.
    assign free     = ~r_rd_vld;
    assign free_oh  = free & (~free + WAYS'(1));
    assign any_hit  = |hit;
    assign any_free = |free;

    // Updated row and result for lookup, insert and remove.
    always_comb begin
        n_vld  = r_rd_vld;
        n_key  = r_rd_key;
        n_val  = r_rd_val;
        we_row = 1'b0;
        res    = '{found: any_hit, value_out: 32'd0, status: STATUS_DONE};
        unique case (r_mode)
            MODE_LOOKUP: begin
                res.value_out = hit_val;
                if (!any_hit) begin
                    res.status = STATUS_ABSENT;
                end
            end
            MODE_INSERT: begin
                if (any_hit) begin
                    we_row = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit[w]) begin
                            n_val[w*32 +: 32] = r_value_in;
                        end
                    end
                end else if (any_free) begin
                    we_row = 1'b1;
                    n_vld  = r_rd_vld | free_oh;
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_oh[w]) begin
                            n_key[w*32 +: 32] = r_key;
                            n_val[w*32 +: 32] = r_value_in;
                        end
                    end
                end else begin
                    res.status = STATUS_FULL;
                end
            end
            MODE_REMOVE: begin
                res.value_out = hit_val;
                if (any_hit) begin
                    we_row = 1'b1;
                    n_vld  = r_rd_vld & ~hit;
                end else begin
                    res.status = STATUS_ABSENT;
                end
            end
            MODE_CLEAR: begin
                res = '{found: 1'b0, value_out: 32'd0, status: STATUS_DONE};
            end
            default: begin
                res = '{found: 1'b0, value_out: 32'd0, status: STATUS_DONE};
            end
        endcase
    end

    // Request capture and bucket row read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_in.mode;
            r_key      <= i_in.key;
            r_value_in <= i_in.value_in;
            r_bucket   <= in_bucket;
            r_rd_vld   <= mem_vld[in_bucket];
            r_rd_key   <= mem_key[in_bucket];
            r_rd_val   <= mem_val[in_bucket];
        end
    end

    // Valid bit memory: the clearing sweep or a write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            mem_vld[r_sweep] <= '0;
        end else if (i_cmd.commit && we_row) begin
            mem_vld[r_bucket] <= n_vld;
        end
    end

    // Key and value memories, written back as whole rows.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we_row) begin
            mem_key[r_bucket] <= n_key;
            mem_val[r_bucket] <= n_val;
        end
    end

    // Sweep row counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sweep_start) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // Result register; it holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.emit_clear) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= res;
        end else if (i_cmd.emit_clear) begin
            r_out <= '{found: 1'b0, value_out: 32'd0, status: STATUS_DONE};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_sts.clear_op   = (r_mode == MODE_CLEAR);
    assign o_sts.sweep_last = (r_sweep == LAST_ROW);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule
